FILE: rtl/core/lir_pkg.sv
package lir_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STEP_NUM    = 125;
  localparam int STEP_DEN    = 96;
  localparam int OFFSET_BITS = 7;

  // grid step walk: offset + STEP_NUM needs one more bit
  localparam int STEP_BITS   = OFFSET_BITS + 1;

  // prev + (cur - prev) * r / STEP_DEN
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int ACC_BITS    = 24;
  // half LSB for rounding plus an offset that keeps the accumulator non-negative
  localparam int ROUND_BIAS  = STEP_DEN / 2 + STEP_DEN * (2 ** SAMPLE_BITS);

  // divide by STEP_DEN = 2^DEN_SHIFT * DEN_ODD
  localparam int DEN_SHIFT   = 5;
  localparam int DEN_ODD     = 3;
  localparam int QUOT_BITS   = ACC_BITS - DEN_SHIFT;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / DEN_ODD + 1;
  localparam int PROD_BITS   = QUOT_BITS + RECIP_SHIFT;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [OFFSET_BITS-1:0]        offset_t;

endpackage

FILE: rtl/core/lir_if.sv
interface lir_sample_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  sample_i;
  lir_pkg::sample_t  sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface lir_result_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  out_i;
  lir_pkg::sample_t  out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink (input valid, input out_i, input out_q, output ready);
endinterface

FILE: rtl/core/lir_lerp.sv
// One channel of the interpolator: difference, multiply by offset,
// exact divide by STEP_DEN through a reciprocal multiply, add back.
module lir_lerp (
  input  logic              clk,
  input  logic              en,
  input  lir_pkg::sample_t  prev,
  input  lir_pkg::sample_t  cur,
  input  lir_pkg::offset_t  r,
  output lir_pkg::sample_t  result
);

  logic signed [lir_pkg::DIFF_BITS-1:0]   diff;
  lir_pkg::sample_t                       a1, a2, a3;
  logic signed [lir_pkg::DIFF_BITS-1:0]   d1;
  lir_pkg::offset_t                       r1;
  logic signed [lir_pkg::ACC_BITS-1:0]    scaled;
  logic [lir_pkg::ACC_BITS-1:0]           t2;
  logic [lir_pkg::QUOT_BITS-1:0]          y2;
  logic [lir_pkg::PROD_BITS-1:0]          p3_next;
  logic [lir_pkg::PROD_BITS-1:0]          p3;
  logic [lir_pkg::QUOT_BITS-1:0]          quot;

  assign diff = {cur[lir_pkg::SAMPLE_BITS-1], cur} - {prev[lir_pkg::SAMPLE_BITS-1], prev};

  assign scaled = d1 * $signed({1'b0, r1});
  assign y2 = t2[lir_pkg::ACC_BITS-1:lir_pkg::DEN_SHIFT];
  assign p3_next = y2 * lir_pkg::RECIP_SHIFT'(lir_pkg::RECIP);
  assign quot = p3[lir_pkg::RECIP_SHIFT +: lir_pkg::QUOT_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= prev;
      d1 <= diff;
      r1 <= r;
      a2 <= a1;
      // wraps into range: the true sum is non-negative and below 2^ACC_BITS
      t2 <= $unsigned(scaled) + lir_pkg::ACC_BITS'(lir_pkg::ROUND_BIAS);
      a3 <= a2;
      p3 <= p3_next;
      // quot carries a +2^SAMPLE_BITS offset, which drops out mod 2^SAMPLE_BITS
      result <= a3 + lir_pkg::SAMPLE_BITS'(quot);
    end
  end

endmodule

FILE: rtl/core/linear_interp_resampler_unit.sv
// Linear interpolation resampler, 96/125 rate (2.5 MS/s in, 1.92 MS/s out) for
// signed 16-bit I/Q. One sample transfer per clock is taken whenever the
// result register is free or being drained; each sample yields zero or one
// result, carried through v1, v2 and v3 into the result register. The first
// sample after reset only primes the previous-sample register. The datapath
// pipeline (difference and offset multiply, reciprocal multiply for the divide
// by 96, final add) advances as one unit and stops only while a result waits.
module linear_interp_resampler_unit (
  input  logic          clk,
  input  logic          rst,
  lir_sample_if.sink    samples,
  lir_result_if.source  results
);

  lir_pkg::sample_t  prev_i, prev_q;
  logic              have_prev;
  lir_pkg::offset_t  grid_offset;
  lir_pkg::offset_t  grid_offset_next;
  logic [lir_pkg::STEP_BITS-1:0] grid_step;
  logic              en, accept, emit;
  logic              v1, v2, v3;

  assign en = !results.valid || results.ready;
  assign samples.ready = en;
  assign accept = samples.valid && en;
  assign emit = have_prev && (grid_offset < lir_pkg::OFFSET_BITS'(lir_pkg::STEP_DEN));

  assign grid_step = {1'b0, grid_offset} + lir_pkg::STEP_BITS'(lir_pkg::STEP_NUM);

  always_comb begin
    grid_offset_next = grid_offset;
    if (!have_prev) begin
      grid_offset_next = '0;
    end else if (emit) begin
      // more than one grid point in one interval is dropped
      if (grid_step >= lir_pkg::STEP_BITS'(lir_pkg::STEP_DEN)) begin
        grid_offset_next = lir_pkg::OFFSET_BITS'(grid_step -
                                                 lir_pkg::STEP_BITS'(lir_pkg::STEP_DEN));
      end else begin
        grid_offset_next = '0;
      end
    end else begin
      grid_offset_next = grid_offset - lir_pkg::OFFSET_BITS'(lir_pkg::STEP_DEN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_i <= '0;
      prev_q <= '0;
      have_prev <= 1'b0;
      grid_offset <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (accept) begin
        prev_i <= samples.sample_i;
        prev_q <= samples.sample_q;
        have_prev <= 1'b1;
        grid_offset <= grid_offset_next;
      end
      if (en) begin
        v1 <= accept && emit;
        v2 <= v1;
        v3 <= v2;
        results.valid <= v3;
      end
    end
  end

  lir_lerp u_lerp_i (
    .clk    (clk),
    .en     (en),
    .prev   (prev_i),
    .cur    (samples.sample_i),
    .r      (grid_offset),
    .result (results.out_i)
  );

  lir_lerp u_lerp_q (
    .clk    (clk),
    .en     (en),
    .prev   (prev_q),
    .cur    (samples.sample_q),
    .r      (grid_offset),
    .result (results.out_q)
  );

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    grid_offset < lir_pkg::OFFSET_BITS'(lir_pkg::STEP_NUM))
    else $error("grid offset out of range");

  a_offset_primed: assert property (@(posedge clk) disable iff (rst)
    !have_prev |-> grid_offset == '0)
    else $error("grid offset nonzero before first sample");

  a_emit_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> v1)
    else $error("result-bearing transfer lost at pipeline entry");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(v3))
    else $error("result appeared without a pipeline item");

  a_no_first_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !have_prev) |=> !v1)
    else $error("first sample produced a result");

endmodule
